[hw/rtl/tapr_pkg.sv]
package tapr_pkg;

    // Coordinate format: signed Q3.16 in 20 bits.
    localparam int COORD_W = 20;
    // Binary angle width and its default.
    localparam int ANGLE_BITS_DEF = 16;
    // Sine and cosine are unsigned Q2.30 magnitudes, signed 32 bits after folding.
    localparam int TRIG_SHIFT = 30;
    localparam int TRIG_W = 32;
    // Taylor series length and pipeline depth of one term.
    localparam int SERIES_TERMS = 8;
    localparam int TERM_STAGES = 3;
    // Reciprocal shift used for the constant divisions.
    localparam int RECIP_SHIFT = 33;
    // pi/2 in Q2.30, split into a 15-bit upper and 16-bit lower half.
    localparam logic [14:0] HALF_PI_HI = 15'h6487;
    localparam logic [15:0] HALF_PI_LO = 16'hED51;
    // Pipeline latencies.
    localparam int SINCOS_LAT = 3 + (SERIES_TERMS - 1) * TERM_STAGES + 1;
    localparam int ROT_LAT = 4;
    localparam int TOTAL_LAT = SINCOS_LAT + ROT_LAT;

    // Quadrant codes from the top two angle bits.
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Saturate a rounded result to the 20-bit coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [24:0] v);
        logic signed [24:0] hi;
        logic signed [24:0] lo;
        hi = 25'sd524287;
        lo = -25'sd524288;
        if (v > hi)
        begin
            return hi[COORD_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

[hw/rtl/tapr_if.sv]
// Input channel: one point and two angles.
interface tapr_in_if #(
    parameter int ANGLE_BITS = tapr_pkg::ANGLE_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic signed [tapr_pkg::COORD_W-1:0] point_x;
    logic signed [tapr_pkg::COORD_W-1:0] point_y;
    logic signed [tapr_pkg::COORD_W-1:0] point_z;
    logic [ANGLE_BITS-1:0]               angle_about_x;
    logic [ANGLE_BITS-1:0]               angle_about_y;

    modport source (output valid, point_x, point_y, point_z, angle_about_x, angle_about_y,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, angle_about_x, angle_about_y,
                  output ready);
endinterface

// Output channel: the rotated point.
interface tapr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tapr_pkg::COORD_W-1:0] rotated_x;
    logic signed [tapr_pkg::COORD_W-1:0] rotated_y;
    logic signed [tapr_pkg::COORD_W-1:0] rotated_z;

    modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
    modport sink (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

[hw/rtl/two_axis_point_rotation.sv]
// Each point passes the sine and cosine stages, then the rotation stages.
// Throughput: one point per cycle; each series term takes three of the
// pipeline stages, and the whole pipeline holds while the output waits.
// Reset: rst_n clears the valid bits only; the datapath is not reset.
module two_axis_point_rotation #(
    parameter int ANGLE_BITS = tapr_pkg::ANGLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tapr_in_if.sink               point_in,
    tapr_out_if.source            point_out
);

    localparam int SL = tapr_pkg::SINCOS_LAT;

    logic                                en;
    logic [SL-1:0]                       vld_reg;
    logic signed [tapr_pkg::COORD_W-1:0] x_reg [SL];
    logic signed [tapr_pkg::COORD_W-1:0] y_reg [SL];
    logic signed [tapr_pkg::COORD_W-1:0] z_reg [SL];
    logic signed [tapr_pkg::TRIG_W-1:0]  sa;
    logic signed [tapr_pkg::TRIG_W-1:0]  ca;
    logic signed [tapr_pkg::TRIG_W-1:0]  sb;
    logic signed [tapr_pkg::TRIG_W-1:0]  cb;

    // The pipeline advances unless a result is held at the output.
    assign en = !point_out.valid || point_out.ready;
    assign point_in.ready = en;

    // Valid bits alongside the sine and cosine pipelines.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[SL-2:0], point_in.valid};
        end
    end

    // Coordinates wait for their angles.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= point_in.point_x;
            y_reg[0] <= point_in.point_y;
            z_reg[0] <= point_in.point_z;
            for (int i = 1; i < SL; i++)
            begin
                x_reg[i] <= x_reg[i-1];
                y_reg[i] <= y_reg[i-1];
                z_reg[i] <= z_reg[i-1];
            end
        end
    end

    tapr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_a (
        .clk     (clk),
        .en      (en),
        .angle   (point_in.angle_about_x),
        .sin_val (sa),
        .cos_val (ca)
    );

    tapr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_b (
        .clk     (clk),
        .en      (en),
        .angle   (point_in.angle_about_y),
        .sin_val (sb),
        .cos_val (cb)
    );

    tapr_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (vld_reg[SL-1]),
        .x         (x_reg[SL-1]),
        .y         (y_reg[SL-1]),
        .z         (z_reg[SL-1]),
        .sa        (sa),
        .ca        (ca),
        .sb        (sb),
        .cb        (cb),
        .valid_out (point_out.valid),
        .rx        (point_out.rotated_x),
        .ry        (point_out.rotated_y),
        .rz        (point_out.rotated_z)
    );

endmodule

[hw/rtl/tapr_series.sv]
// Pipelined Taylor series: three register stages per term after the first.
// Each term is (term * t2) >> 30 divided by a constant through a reciprocal
// multiply with a single correction step.
module tapr_series #(
    parameter bit IS_SIN = 1'b1
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [31:0]              first,
    input  logic [31:0]              t2,
    output logic signed [33:0]       sum
);

    localparam int NT = tapr_pkg::SERIES_TERMS - 1;

    logic [31:0]        prod_reg [NT];
    logic [31:0]        t2a_reg  [NT];
    logic signed [33:0] suma_reg [NT];
    logic [31:0]        quo_reg  [NT];
    logic [31:0]        vb_reg   [NT];
    logic [31:0]        t2b_reg  [NT];
    logic signed [33:0] sumb_reg [NT];
    logic [31:0]        term_reg [NT];
    logic [31:0]        t2c_reg  [NT];
    logic signed [33:0] sumc_reg [NT];

    for (genvar k = 0; k < NT; k++)
    begin : g_term
        localparam int N = k + 1;
        localparam int DIV = IS_SIN ? (2 * N) * (2 * N + 1) : (2 * N - 1) * (2 * N);
        localparam logic [33:0] RECIP = 34'((64'd1 << tapr_pkg::RECIP_SHIFT) / DIV);
        localparam logic [7:0] DIV8 = 8'(DIV);

        logic [31:0]        term_in;
        logic [31:0]        t2_in;
        logic signed [33:0] sum_in;
        logic [63:0]        prod_full;
        logic [65:0]        quo_full;
        logic [39:0]        back;
        logic [39:0]        rem;
        logic [31:0]        quo_fix;

        // Select the previous term or the series head.
        if (k == 0)
        begin : g_head
            assign term_in = first;
            assign t2_in   = t2;
            assign sum_in  = $signed({2'b00, first});
        end
        else
        begin : g_link
            assign term_in = term_reg[k-1];
            assign t2_in   = t2c_reg[k-1];
            assign sum_in  = sumc_reg[k-1];
        end

        // Multiply, reciprocal divide and correction arithmetic.
        always_comb
        begin
            prod_full = 64'(term_in) * 64'(t2_in);
            quo_full  = 66'(prod_reg[k]) * 66'(RECIP);
            back      = 40'(quo_reg[k]) * 40'(DIV8);
            rem       = 40'(vb_reg[k]) - back;
            quo_fix   = (rem >= 40'(DIV8)) ? quo_reg[k] + 32'd1 : quo_reg[k];
        end

        // Three stages per term.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[k] <= prod_full[tapr_pkg::TRIG_SHIFT +: 32];
                t2a_reg[k]  <= t2_in;
                suma_reg[k] <= sum_in;
                quo_reg[k]  <= quo_full[tapr_pkg::RECIP_SHIFT +: 32];
                vb_reg[k]   <= prod_reg[k];
                t2b_reg[k]  <= t2a_reg[k];
                sumb_reg[k] <= suma_reg[k];
                term_reg[k] <= quo_fix;
                t2c_reg[k]  <= t2b_reg[k];
                if (N % 2 == 1)
                begin
                    sumc_reg[k] <= sumb_reg[k] - $signed({2'b00, quo_fix});
                end
                else
                begin
                    sumc_reg[k] <= sumb_reg[k] + $signed({2'b00, quo_fix});
                end
            end
        end
    end

    assign sum = sumc_reg[NT-1];

endmodule

[hw/rtl/tapr_sincos.sv]
// Sine and cosine of a binary angle in signed Q1.30: angle scaling,
// squaring, two series pipelines and quadrant folding.
module tapr_sincos #(
    parameter int ANGLE_BITS = tapr_pkg::ANGLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [ANGLE_BITS-1:0]                angle,
    output logic signed [tapr_pkg::TRIG_W-1:0]   sin_val,
    output logic signed [tapr_pkg::TRIG_W-1:0]   cos_val
);

    localparam int RW = ANGLE_BITS - 2;
    localparam int QD = tapr_pkg::SINCOS_LAT - 1;

    logic [RW+15:0]         plo_reg;
    logic [RW+14:0]         phi_reg;
    logic [30:0]            theta_reg;
    logic [30:0]            theta_d_reg;
    logic [31:0]            t2_reg;
    tapr_pkg::quad_t        q_reg [QD];
    logic signed [tapr_pkg::TRIG_W-1:0] sin_reg;
    logic signed [tapr_pkg::TRIG_W-1:0] cos_reg;

    logic [RW+30:0]         theta_full;
    logic [61:0]            sq_full;
    logic signed [33:0]     s_sum;
    logic signed [33:0]     c_sum;
    logic signed [tapr_pkg::TRIG_W-1:0] s_cl;
    logic signed [tapr_pkg::TRIG_W-1:0] c_cl;
    logic signed [tapr_pkg::TRIG_W-1:0] sin_next;
    logic signed [tapr_pkg::TRIG_W-1:0] cos_next;

    // Scale the in-quadrant angle to radians and square it.
    always_comb
    begin
        theta_full = (RW+31)'(phi_reg) * (RW+31)'(17'h10000) + (RW+31)'(plo_reg);
        sq_full    = 62'(theta_reg) * 62'(theta_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg     <= (RW+16)'(angle[RW-1:0]) * (RW+16)'(tapr_pkg::HALF_PI_LO);
            phi_reg     <= (RW+15)'(angle[RW-1:0]) * (RW+15)'(tapr_pkg::HALF_PI_HI);
            theta_reg   <= theta_full[RW +: 31];
            t2_reg      <= sq_full[tapr_pkg::TRIG_SHIFT +: 32];
            theta_d_reg <= theta_reg;
            q_reg[0]    <= tapr_pkg::quad_t'(angle[ANGLE_BITS-1 -: 2]);
            for (int i = 1; i < QD; i++)
            begin
                q_reg[i] <= q_reg[i-1];
            end
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    tapr_series #(.IS_SIN(1'b1)) u_sin (
        .clk   (clk),
        .en    (en),
        .first ({1'b0, theta_d_reg}),
        .t2    (t2_reg),
        .sum   (s_sum)
    );

    tapr_series #(.IS_SIN(1'b0)) u_cos (
        .clk   (clk),
        .en    (en),
        .first (32'd1 << tapr_pkg::TRIG_SHIFT),
        .t2    (t2_reg),
        .sum   (c_sum)
    );

    // Clamp to [0, 1.0] and fold by quadrant.
    always_comb
    begin
        if (s_sum < 0)
        begin
            s_cl = '0;
        end
        else if (s_sum > 34'sd1073741824)
        begin
            s_cl = 32'sd1073741824;
        end
        else
        begin
            s_cl = s_sum[31:0];
        end
        if (c_sum < 0)
        begin
            c_cl = '0;
        end
        else if (c_sum > 34'sd1073741824)
        begin
            c_cl = 32'sd1073741824;
        end
        else
        begin
            c_cl = c_sum[31:0];
        end
        case (q_reg[QD-1])
            tapr_pkg::QUAD_0:
            begin
                sin_next = s_cl;
                cos_next = c_cl;
            end
            tapr_pkg::QUAD_1:
            begin
                sin_next = c_cl;
                cos_next = -s_cl;
            end
            tapr_pkg::QUAD_2:
            begin
                sin_next = -s_cl;
                cos_next = -c_cl;
            end
            default:
            begin
                sin_next = -c_cl;
                cos_next = s_cl;
            end
        endcase
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

[hw/rtl/tapr_rotate.sv]
// Two rotations by sine and cosine: products, rounded sums, then the
// second set of products and a saturating output register.
module tapr_rotate (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 valid_in,
    input  logic signed [tapr_pkg::COORD_W-1:0]  x,
    input  logic signed [tapr_pkg::COORD_W-1:0]  y,
    input  logic signed [tapr_pkg::COORD_W-1:0]  z,
    input  logic signed [tapr_pkg::TRIG_W-1:0]   sa,
    input  logic signed [tapr_pkg::TRIG_W-1:0]   ca,
    input  logic signed [tapr_pkg::TRIG_W-1:0]   sb,
    input  logic signed [tapr_pkg::TRIG_W-1:0]   cb,
    output logic                                 valid_out,
    output logic signed [tapr_pkg::COORD_W-1:0]  rx,
    output logic signed [tapr_pkg::COORD_W-1:0]  ry,
    output logic signed [tapr_pkg::COORD_W-1:0]  rz
);

    localparam logic signed [54:0] HALF = 55'sd1 <<< (tapr_pkg::TRIG_SHIFT - 1);

    logic [tapr_pkg::ROT_LAT-1:0]          vld_reg;
    logic signed [51:0]                    yca_reg;
    logic signed [51:0]                    zsa_reg;
    logic signed [51:0]                    zca_reg;
    logic signed [51:0]                    ysa_reg;
    logic signed [tapr_pkg::TRIG_W-1:0]    sb1_reg;
    logic signed [tapr_pkg::TRIG_W-1:0]    cb1_reg;
    logic signed [tapr_pkg::TRIG_W-1:0]    sb2_reg;
    logic signed [tapr_pkg::TRIG_W-1:0]    cb2_reg;
    logic signed [tapr_pkg::COORD_W-1:0]   x1_reg;
    logic signed [tapr_pkg::COORD_W-1:0]   x2_reg;
    logic signed [tapr_pkg::COORD_W-1:0]   y1_reg;
    logic signed [tapr_pkg::COORD_W-1:0]   y1d_reg;
    logic signed [20:0]                    z1_reg;
    logic signed [52:0]                    xcb_reg;
    logic signed [52:0]                    z1sb_reg;
    logic signed [52:0]                    z1cb_reg;
    logic signed [52:0]                    xsb_reg;
    logic signed [tapr_pkg::COORD_W-1:0]   rx_reg;
    logic signed [tapr_pkg::COORD_W-1:0]   ry_reg;
    logic signed [tapr_pkg::COORD_W-1:0]   rz_reg;

    logic signed [54:0] s_y1;
    logic signed [54:0] s_z1;
    logic signed [54:0] s_xr;
    logic signed [54:0] s_zr;

    // Rounded sums, half toward plus infinity.
    always_comb
    begin
        s_y1 = 55'(yca_reg) + 55'(zsa_reg) + HALF;
        s_z1 = 55'(zca_reg) - 55'(ysa_reg) + HALF;
        s_xr = 55'(xcb_reg) - 55'(z1sb_reg) + HALF;
        s_zr = 55'(z1cb_reg) + 55'(xsb_reg) + HALF;
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[tapr_pkg::ROT_LAT-2:0], valid_in};
        end
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yca_reg  <= 52'(y) * 52'(ca);
            zsa_reg  <= 52'(z) * 52'(sa);
            zca_reg  <= 52'(z) * 52'(ca);
            ysa_reg  <= 52'(y) * 52'(sa);
            sb1_reg  <= sb;
            cb1_reg  <= cb;
            x1_reg   <= x;
            y1_reg   <= tapr_pkg::sat_coord(s_y1[54:30]);
            z1_reg   <= s_z1[50:30];
            sb2_reg  <= sb1_reg;
            cb2_reg  <= cb1_reg;
            x2_reg   <= x1_reg;
            xcb_reg  <= 53'(x2_reg) * 53'(cb2_reg);
            z1sb_reg <= 53'(z1_reg) * 53'(sb2_reg);
            z1cb_reg <= 53'(z1_reg) * 53'(cb2_reg);
            xsb_reg  <= 53'(x2_reg) * 53'(sb2_reg);
            y1d_reg  <= y1_reg;
            rx_reg   <= tapr_pkg::sat_coord(s_xr[54:30]);
            ry_reg   <= y1d_reg;
            rz_reg   <= tapr_pkg::sat_coord(s_zr[54:30]);
        end
    end

    assign valid_out = vld_reg[tapr_pkg::ROT_LAT-1];
    assign rx = rx_reg;
    assign ry = ry_reg;
    assign rz = rz_reg;

endmodule

[hw/rtl/tapr_checker.sv]
// Port-level checks on the rotation pipeline.
module tapr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [tapr_pkg::COORD_W-1:0] rx,
    input logic signed [tapr_pkg::COORD_W-1:0] ry,
    input logic signed [tapr_pkg::COORD_W-1:0] rz
);

    // A waiting result stays and keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rx) && $stable(ry) && $stable(rz))
        else $error("output changed while stalled");

    // The input is held back only while a result waits at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // A waiting result always stalls the input.
    a_stall_apply: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output stalled");

    // No result is present when reset is released.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind two_axis_point_rotation tapr_checker u_tapr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (point_in.valid),
    .in_ready  (point_in.ready),
    .out_valid (point_out.valid),
    .out_ready (point_out.ready),
    .rx        (point_out.rotated_x),
    .ry        (point_out.rotated_y),
    .rz        (point_out.rotated_z)
);

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int ABITS = tapr_pkg::ANGLE_BITS_DEF;
    localparam longint HALF_PI_Q30 = 64'd3373259426 >> 1;
    localparam int N_RANDOM = 880;

    typedef logic signed [tapr_pkg::COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t          x;
        coord_t          y;
        coord_t          z;
        logic [ABITS-1:0] ax;
        logic [ABITS-1:0] ay;
    } point_req_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_res_t;

    // One directed row: the request, and optionally a result known at a glance.
    typedef struct packed {
        point_req_t req;
        logic       has_known;
        point_res_t known;
    } stim_row_t;

    logic clk;
    logic rst_n;
    int   n_errors;
    int   n_checked;

    point_res_t rotated_q[$];

    tapr_in_if #(.ANGLE_BITS(ABITS)) point_in();
    tapr_out_if                      point_out();

    two_axis_point_rotation #(.ANGLE_BITS(ABITS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .point_in  (point_in.sink),
        .point_out (point_out.source)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Taylor series in Q2.30 with alternating signs, clamped to [0, 1.0].
    function automatic longint trig_series(input longint first, input longint t2,
                                           input longint n0);
        longint term;
        longint sum;
        longint n;
        term = first;
        sum = first;
        n = n0;
        for (int k = 1; k < tapr_pkg::SERIES_TERMS; k++)
        begin
            term = ((term * t2) >>> tapr_pkg::TRIG_SHIFT) / ((n + 1) * (n + 2));
            n += 2;
            if (k % 2 == 1)
            begin
                sum -= term;
            end
            else
            begin
                sum += term;
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > (64'sd1 <<< tapr_pkg::TRIG_SHIFT))
        begin
            sum = 64'sd1 <<< tapr_pkg::TRIG_SHIFT;
        end
        return sum;
    endfunction

    // Sine and cosine of a binary angle by quadrant folding.
    function automatic void angle_sin_cos(input logic [ABITS-1:0] ang, output longint s,
                                          output longint c);
        tapr_pkg::quad_t q;
        longint r;
        longint theta;
        longint t2;
        longint ss;
        longint cc;
        q = tapr_pkg::quad_t'(ang[ABITS-1 -: 2]);
        r = longint'(ang[ABITS-3:0]);
        theta = (r * HALF_PI_Q30) >>> (ABITS - 2);
        t2 = (theta * theta) >>> tapr_pkg::TRIG_SHIFT;
        ss = trig_series(theta, t2, 1);
        cc = trig_series(64'sd1 <<< tapr_pkg::TRIG_SHIFT, t2, 0);
        case (q)
            tapr_pkg::QUAD_0:
            begin
                s = ss;
                c = cc;
            end
            tapr_pkg::QUAD_1:
            begin
                s = cc;
                c = -ss;
            end
            tapr_pkg::QUAD_2:
            begin
                s = -ss;
                c = -cc;
            end
            default:
            begin
                s = -cc;
                c = ss;
            end
        endcase
    endfunction

    // Round a Q30-scaled sum half toward plus infinity.
    function automatic longint round_q30(input longint v);
        return (v + (64'sd1 <<< (tapr_pkg::TRIG_SHIFT - 1))) >>> tapr_pkg::TRIG_SHIFT;
    endfunction

    function automatic coord_t clamp_coord(input longint v);
        if (v > 524287)
        begin
            return coord_t'(524287);
        end
        if (v < -524288)
        begin
            return coord_t'(-524288);
        end
        return coord_t'(v);
    endfunction

    // Rotate about x by the first angle, then about y by the second.
    function automatic point_res_t rotate_point(input point_req_t p);
        longint sa, ca, sb, cb;
        longint x, y, z, y1, z1;
        point_res_t r;
        angle_sin_cos(p.ax, sa, ca);
        angle_sin_cos(p.ay, sb, cb);
        x = p.x;
        y = p.y;
        z = p.z;
        y1 = round_q30(y * ca + z * sa);
        z1 = round_q30(z * ca - y * sa);
        r.x = clamp_coord(round_q30(x * cb - z1 * sb));
        r.y = clamp_coord(y1);
        r.z = clamp_coord(round_q30(z1 * cb + x * sb));
        return r;
    endfunction

    function automatic stim_row_t row(input int x, input int y, input int z,
                                      input int ax, input int ay, input bit known,
                                      input int ex, input int ey, input int ez);
        stim_row_t s;
        s.req = '{coord_t'(x), coord_t'(y), coord_t'(z), ABITS'(ax), ABITS'(ay)};
        s.has_known = known;
        s.known = '{coord_t'(ex), coord_t'(ey), coord_t'(ez)};
        return s;
    endfunction

    // Draw a coordinate biased toward the extremes and small values.
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'(524287 - $urandom_range(0, 3));
            1: return coord_t'(-524288 + $urandom_range(0, 3));
            2: return coord_t'($urandom_range(0, 200) - 100);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [ABITS-1:0] rand_angle();
        logic [ABITS-1:0] a;
        a = ABITS'($urandom);
        case ($urandom_range(0, 4))
            0: a[ABITS-3:0] = '0;
            1: a[ABITS-3:0] = '1;
            default: ;
        endcase
        return a;
    endfunction

    // Drive one point after a random gap; valid stays high when there is no gap.
    task automatic send_point(input point_req_t p);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap != 0)
        begin
            if (point_in.valid)
            begin
                point_in.valid <= 1'b0;
            end
            repeat (gap) @(negedge clk);
        end
        point_in.valid         <= 1'b1;
        point_in.point_x       <= p.x;
        point_in.point_y       <= p.y;
        point_in.point_z       <= p.z;
        point_in.angle_about_x <= p.ax;
        point_in.angle_about_y <= p.ay;
        do
        begin
            @(posedge clk);
        end
        while (!point_in.ready);
        rotated_q.push_back(rotate_point(p));
        @(negedge clk);
    endtask

    // Stimulus: directed table, then random points.
    initial
    begin
        stim_row_t  table_rows[$];
        point_req_t p;
        point_res_t got;
        n_errors = 0;
        n_checked = 0;
        rst_n = 1'b0;
        point_in.valid = 1'b0;
        point_in.point_x = '0;
        point_in.point_y = '0;
        point_in.point_z = '0;
        point_in.angle_about_x = '0;
        point_in.angle_about_y = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero angles leave the point as it is; half turns negate coordinates.
        table_rows.push_back(row(0, 0, 0, 0, 0, 1, 0, 0, 0));
        table_rows.push_back(row(65536, -65536, 32768, 0, 0, 1, 65536, -65536, 32768));
        table_rows.push_back(row(524287, 524287, 524287, 0, 0, 1, 524287, 524287, 524287));
        table_rows.push_back(row(-524288, -524288, -524288, 0, 0, 1,
                                 -524288, -524288, -524288));
        table_rows.push_back(row(65536, 65536, 65536, 32768, 32768, 1, -65536, -65536, 65536));
        table_rows.push_back(row(-524288, -524288, -524288, 32768, 0, 1,
                                 -524288, 524287, 524287));
        // Quarter turns, diagonals, all four quadrants and overflow at 45 degrees.
        table_rows.push_back(row(65536, 65536, 65536, 16384, 0, 0, 0, 0, 0));
        table_rows.push_back(row(65536, 65536, 65536, 0, 16384, 0, 0, 0, 0));
        table_rows.push_back(row(65536, 65536, 65536, 49152, 49152, 0, 0, 0, 0));
        table_rows.push_back(row(524287, 524287, 524287, 8192, 8192, 0, 0, 0, 0));
        table_rows.push_back(row(-524288, 524287, -524288, 24576, 40960, 0, 0, 0, 0));
        table_rows.push_back(row(524287, -524288, 524287, 57344, 8192, 0, 0, 0, 0));
        table_rows.push_back(row(1, -1, 1, 16383, 65535, 0, 0, 0, 0));
        table_rows.push_back(row(-1, 1, -1, 65535, 16383, 0, 0, 0, 0));
        table_rows.push_back(row(100000, -200000, 300000, 12345, 54321, 0, 0, 0, 0));
        table_rows.push_back(row(-524288, -524288, -524288, 49151, 32767, 0, 0, 0, 0));

        foreach (table_rows[i])
        begin
            p = table_rows[i].req;
            got = rotate_point(p);
            if (table_rows[i].has_known && got != table_rows[i].known)
            begin
                $display("%0t: table row %0d: predictor gives %0d %0d %0d, row says %0d %0d %0d",
                         $time, i, got.x, got.y, got.z, table_rows[i].known.x,
                         table_rows[i].known.y, table_rows[i].known.z);
                n_errors++;
            end
            send_point(p);
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // Hold off once until the pipeline has drained.
            if (i == N_RANDOM / 2)
            begin
                point_in.valid <= 1'b0;
                while (rotated_q.size() != 0) @(negedge clk);
            end
            p.x = rand_coord();
            p.y = rand_coord();
            p.z = rand_coord();
            p.ax = rand_angle();
            p.ay = rand_angle();
            send_point(p);
        end
        point_in.valid <= 1'b0;

        while (rotated_q.size() != 0) @(negedge clk);
        repeat (tapr_pkg::TOTAL_LAT + 10) @(negedge clk);
        $display("Rotated %0d points (directed extremes, all quadrants, random stalls).",
                 n_checked);
        if (n_errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Output side: random stalls, with runs of no stall.
    initial
    begin
        int wait_cycles;
        point_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                point_out.ready <= 1'b1;
            end
            else
            begin
                wait_cycles = $urandom_range(0, 9);
                if (wait_cycles == 0)
                begin
                    point_out.ready <= 1'b1;
                end
                else
                begin
                    point_out.ready <= 1'b0;
                    repeat (wait_cycles) @(negedge clk);
                    point_out.ready <= 1'b1;
                end
            end
        end
    end

    // Check each output transfer against the oldest prediction.
    always @(posedge clk)
    begin
        point_res_t exp_res;
        if (rst_n && point_out.valid && point_out.ready)
        begin
            if (rotated_q.size() == 0)
            begin
                $display("%0t: unexpected result %0d %0d %0d", $time, point_out.rotated_x,
                         point_out.rotated_y, point_out.rotated_z);
                n_errors++;
            end
            else
            begin
                exp_res = rotated_q.pop_front();
                n_checked++;
                if (point_out.rotated_x !== exp_res.x)
                begin
                    $display("%0t: rotated_x expected %0d actual %0d", $time, exp_res.x,
                             point_out.rotated_x);
                    n_errors++;
                end
                if (point_out.rotated_y !== exp_res.y)
                begin
                    $display("%0t: rotated_y expected %0d actual %0d", $time, exp_res.y,
                             point_out.rotated_y);
                    n_errors++;
                end
                if (point_out.rotated_z !== exp_res.z)
                begin
                    $display("%0t: rotated_z expected %0d actual %0d", $time, exp_res.z,
                             point_out.rotated_z);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding.", rotated_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
